### design/assert_macros.svh
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define CRC16PR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define CRC16PR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/crc16pr_pkg.sv
// ----------------------------------------------------------------------------
// crc16pr_pkg
// Types and constants shared by the framed packet receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package crc16pr_pkg;

  // register reset values
  localparam logic [7:0]  START_BYTE_RST = 8'hA1;
  localparam logic [7:0]  MAX_LENGTH_RST = 8'd200;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;

  // register indexes, taken from byte address bit 2
  localparam logic REG_START_BYTE = 1'b0;
  localparam logic REG_MAX_LENGTH = 1'b1;

  // parser phase
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_TYPE    = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_CRC_LO  = 3'd3,
    PH_CRC_HI  = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  // configuration seen by the parser
  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] max_length;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    logic       frame_end;
    logic       crc_ok;
    logic [7:0] frame_type;
    logic [7:0] frame_length;
    logic       length_error;
  } res_t;

endpackage

`default_nettype wire

### design/crc16pr_regs.sv
// ----------------------------------------------------------------------------
// crc16pr_regs
// APB-style configuration registers: start byte and maximum payload length.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16pr_regs
  import crc16pr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic [7:0] start_byte_r;
  logic [7:0] max_length_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RST;
      max_length_r <= MAX_LENGTH_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_START_BYTE: start_byte_r <= pwdata[7:0];
        REG_MAX_LENGTH: max_length_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[2])
      REG_START_BYTE: prdata = {24'd0, start_byte_r};
      REG_MAX_LENGTH: prdata = {24'd0, max_length_r};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg.start_byte = start_byte_r;
  assign cfg.max_length = max_length_r;

endmodule

`default_nettype wire

### design/crc16pr_parser.sv
// ----------------------------------------------------------------------------
// crc16pr_parser
// Frame state, running CRC-16 (reflected, poly 0x8408) and per-byte result.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16pr_parser
  import crc16pr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire logic [7:0] rx_byte,
  input  wire cfg_t       cfg,
  output res_t            res
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  held_type_r, held_type_nxt;
  logic [7:0]  held_length_r, held_length_nxt;
  logic [15:0] received_crc_r, received_crc_nxt;
  logic [15:0] running_crc_r, running_crc_nxt;
  logic [7:0]  byte_count_r, byte_count_nxt;

  // one byte of the reflected crc, table-free form
  function automatic logic [15:0] crc_step(input logic [7:0] b, input logic [15:0] crc);
    logic [7:0]  x;
    logic [15:0] xw;
    x  = b ^ crc[7:0];
    x  = x ^ {x[3:0], 4'd0};
    xw = {8'd0, x};
    return {x, crc[15:8]} ^ (xw >> 4) ^ (xw << 3);
  endfunction

  logic [15:0] crc_seed;
  logic [15:0] crc_upd;
  logic [15:0] rx_crc_full;
  logic [8:0]  count_inc;

  // the type byte restarts the crc
  assign crc_seed    = (phase_r == PH_TYPE) ? CRC_INIT : running_crc_r;
  assign crc_upd     = crc_step(rx_byte, crc_seed);
  assign rx_crc_full = {rx_byte, received_crc_r[7:0]};
  assign count_inc   = {1'b0, byte_count_r} + 9'd1;

  // next state and result
  always_comb begin
    phase_nxt        = phase_r;
    held_type_nxt    = held_type_r;
    held_length_nxt  = held_length_r;
    received_crc_nxt = received_crc_r;
    running_crc_nxt  = running_crc_r;
    byte_count_nxt   = byte_count_r;
    res              = '0;

    case (phase_r)
      PH_TYPE: begin
        held_type_nxt   = rx_byte;
        running_crc_nxt = crc_upd;
        phase_nxt       = PH_LENGTH;
      end
      PH_LENGTH: begin
        if (rx_byte > cfg.max_length) begin
          res.length_error = 1'b1;
          phase_nxt        = PH_HUNT;
        end else begin
          held_length_nxt = rx_byte;
          running_crc_nxt = crc_upd;
          phase_nxt       = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        received_crc_nxt = {8'd0, rx_byte};
        phase_nxt        = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        received_crc_nxt = rx_crc_full;
        if (held_length_r == 8'd0) begin
          res.frame_end = 1'b1;
          res.crc_ok    = (running_crc_r == rx_crc_full);
          phase_nxt     = PH_HUNT;
        end else begin
          byte_count_nxt = 8'd0;
          phase_nxt      = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res.data_valid  = 1'b1;
        res.data_byte   = rx_byte;
        res.data_index  = byte_count_r;
        running_crc_nxt = crc_upd;
        if (count_inc >= {1'b0, held_length_r}) begin
          res.frame_end = 1'b1;
          res.crc_ok    = (crc_upd == received_crc_r);
          phase_nxt     = PH_HUNT;
        end else begin
          byte_count_nxt = count_inc[7:0];
        end
      end
      default: begin
        // hunting, and any unused phase code
        phase_nxt = (rx_byte == cfg.start_byte) ? PH_TYPE : PH_HUNT;
      end
    endcase

    res.frame_type   = held_type_nxt;
    res.frame_length = held_length_nxt;
  end

  // state update on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HUNT;
      held_type_r    <= 8'd0;
      held_length_r  <= 8'd0;
      received_crc_r <= 16'd0;
      running_crc_r  <= CRC_INIT;
      byte_count_r   <= 8'd0;
    end else if (step_en) begin
      phase_r        <= phase_nxt;
      held_type_r    <= held_type_nxt;
      held_length_r  <= held_length_nxt;
      received_crc_r <= received_crc_nxt;
      running_crc_r  <= running_crc_nxt;
      byte_count_r   <= byte_count_nxt;
    end
  end

endmodule

`default_nettype wire

### design/crc16_packet_receiver.sv
// ----------------------------------------------------------------------------
// crc16_packet_receiver
// Framed packet receiver with CRC-16 check, one byte in and one result out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one received byte per transfer (tdata = rx_byte).
//   out_* : one result per input byte; tlast = frame_end, tuser = data_valid,
//           tdata carries payload byte, index, crc status, type, length and
//           the length error flag.
//   cfg_* : APB-style port, start_byte at 0x0, max_length at 0x4; write only
//           while the stream is idle.
// The result of an input transfer is registered and shows on out_* in the cycle after it.
// Throughput is one byte per cycle: the frame state and the byte-wide CRC
// update sit between the state registers and the output register, and a new
// byte is taken whenever the output register is empty or being drained.
// When the receiver stalls, the result is held and in_tready drops until it
// is taken. Reset empties the output register, returns the parser to hunting
// for the start byte and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_packet_receiver
  import crc16pr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] rx_byte
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,   // [7:0] data_byte, [15:8] data_index,
                                        // [16] crc_ok, [24:17] frame_type,
                                        // [32:25] frame_length, [33] length_error
  output logic             out_tlast,   // frame_end
  output logic             out_tuser,   // [0] data_valid
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

`include "assert_macros.svh"

  cfg_t cfg;
  res_t res;
  res_t res_r;
  logic out_valid_r;
  logic in_xfer;

  // configuration registers
  crc16pr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // input handshake
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  // parser
  crc16pr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_xfer),
    .rx_byte (in_tdata),
    .cfg     (cfg),
    .res     (res)
  );

  // output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = res_r.frame_end;
  assign out_tuser  = res_r.data_valid;
  assign out_tdata  = {6'd0, res_r.length_error, res_r.frame_length, res_r.frame_type,
                       res_r.crc_ok, res_r.data_index, res_r.data_byte};

  // checks
  `CRC16PR_ASSERT(a_index_in_frame, out_valid_r && res_r.data_valid |-> res_r.data_index < res_r.frame_length, "payload index beyond frame length")
  `CRC16PR_ASSERT(a_len_err_alone, out_valid_r && res_r.length_error |-> !res_r.frame_end && !res_r.data_valid, "length error with payload or frame end")
  `CRC16PR_ASSERT(a_crc_ok_at_end, out_valid_r && res_r.crc_ok |-> res_r.frame_end, "crc_ok without frame end")
  `CRC16PR_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r, "output valid after reset")

endmodule

`default_nettype wire
